>>> rtl/udpfhc_pkg.sv
// Shared types, constants and helper functions for the UDP forward header checksum block.
// Used by every module of the block; depends on nothing.
package udpfhc_pkg;

	localparam int MAX_SUM_BYTES_DEF   = 1480;
	localparam int MAX_FRAME_BYTES_DEF = 2048;

	localparam int UDP_START     = 34;
	localparam int MIN_FRAME     = 42;
	localparam int POS_ETHERTYPE = 13;
	localparam int POS_HDR_FIRST = 15;
	localparam int POS_HDR_LAST  = 23;
	localparam int POS_PROTO     = 23;
	localparam int POS_DPORT     = 37;
	localparam int POS_ULEN      = 39;
	localparam int POS_UCHECK    = 41;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	localparam int HSUM_W = 19;
	localparam int HFIN_W = 20;
	localparam int ADDR_W = 18;

	localparam logic [15:0] LISTEN_PORT_RST = 16'd7999;
	localparam logic [31:0] NEW_SRC_IP_RST  = 32'd3232299371;
	localparam logic [31:0] NEW_DST_IP_RST  = 32'd3232299314;
	localparam logic [15:0] EGRESS_IF_RST   = 16'd5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LISTEN_PORT = 2'd0,
		REG_NEW_SRC_IP  = 2'd1,
		REG_NEW_DST_IP  = 2'd2,
		REG_EGRESS_IF   = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [15:0] listen_port;
		logic [31:0] new_source_ip;
		logic [31:0] new_dest_ip;
		logic [15:0] egress_interface;
	} cfg_t;

	typedef struct packed {
		logic        long_enough;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [15:0] dest_port;
		logic [15:0] udp_length;
	} frame_info_t;

	function automatic int psum_width(input int max_sum);
		return $clog2((max_sum / 2 + 1) * 65535 + 1);
	endfunction

	function automatic logic [15:0] finish_sum(input logic [31:0] s);
		logic [31:0] t;
		t = {16'b0, s[15:0]} + {16'b0, s[31:16]};
		t = {16'b0, t[15:0]} + {16'b0, t[31:16]};
		return ~t[15:0];
	endfunction

endpackage

>>> rtl/udpfhc_byte_if.sv
// Byte stream channel carrying one frame byte and its end-of-frame flag per beat.
// Standalone interface; no package dependency.
interface udpfhc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

>>> rtl/udpfhc_result_if.sv
// Result channel carrying the verdict, egress interface and both checksums per beat.
// Standalone interface; no package dependency.
interface udpfhc_result_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic [15:0] out_interface;
	logic [15:0] header_checksum;
	logic [15:0] udp_checksum;

	modport source (output valid, verdict, out_interface, header_checksum, udp_checksum,
		input ready);
	modport sink (input valid, verdict, out_interface, header_checksum, udp_checksum,
		output ready);
endinterface

>>> rtl/udp_forward_header_checksum.sv
// Top level of the UDP forward header checksum block: config registers, byte accumulator, finish stage.
// Depends on udpfhc_pkg, udpfhc_byte_if, udpfhc_result_if, udpfhc_cfg, udpfhc_accum, udpfhc_finish.
//
// The block takes one frame byte per cycle while it is not stalled, with no gaps needed between frames.
// Each byte updates the running header and UDP sums directly, which sets the rate of one beat per clock. On
// the last byte the frame summary is registered; the finish stage then adds the new addresses, folds
// the carries and registers the result beat. The frame input stalls only while a finished summary
// waits behind an unread result beat.
module udp_forward_header_checksum #(
	parameter int MAX_SUM_BYTES   = udpfhc_pkg::MAX_SUM_BYTES_DEF,
	parameter int MAX_FRAME_BYTES = udpfhc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [udpfhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [udpfhc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	udpfhc_byte_if.sink                       frame,
	udpfhc_result_if.source                   result
);

	localparam int PSUM_W = udpfhc_pkg::psum_width(MAX_SUM_BYTES);

	udpfhc_pkg::cfg_t              cfg;
	udpfhc_pkg::frame_info_t       info_s1;
	logic                          s1_valid;
	logic                          fin_ready;
	logic [udpfhc_pkg::HSUM_W-1:0] hsum_s1;
	logic [PSUM_W-1:0]             psum_s1;

	udpfhc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	udpfhc_accum #(
		.MAX_SUM_BYTES   (MAX_SUM_BYTES),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.PSUM_W          (PSUM_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.fin_ready (fin_ready),
		.s1_valid  (s1_valid),
		.info_s1   (info_s1),
		.hsum_s1   (hsum_s1),
		.psum_s1   (psum_s1)
	);

	udpfhc_finish #(
		.MAX_SUM_BYTES (MAX_SUM_BYTES),
		.PSUM_W        (PSUM_W)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s1_valid  (s1_valid),
		.info_s1   (info_s1),
		.hsum_s1   (hsum_s1),
		.psum_s1   (psum_s1),
		.fin_ready (fin_ready),
		.result    (result)
	);

endmodule

>>> rtl/udpfhc_cfg.sv
// Configuration register file for the UDP forward header checksum block.
// Depends on udpfhc_pkg for register codes, reset values and the cfg_t type.
module udpfhc_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [udpfhc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [udpfhc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output udpfhc_pkg::cfg_t                     cfg
);

	udpfhc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.listen_port      <= udpfhc_pkg::LISTEN_PORT_RST;
			cfg_q.new_source_ip    <= udpfhc_pkg::NEW_SRC_IP_RST;
			cfg_q.new_dest_ip      <= udpfhc_pkg::NEW_DST_IP_RST;
			cfg_q.egress_interface <= udpfhc_pkg::EGRESS_IF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				udpfhc_pkg::REG_LISTEN_PORT: cfg_q.listen_port <= cfg_wdata[15:0];
				udpfhc_pkg::REG_NEW_SRC_IP:  cfg_q.new_source_ip <= cfg_wdata;
				udpfhc_pkg::REG_NEW_DST_IP:  cfg_q.new_dest_ip <= cfg_wdata;
				udpfhc_pkg::REG_EGRESS_IF:   cfg_q.egress_interface <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/udpfhc_accum.sv
// Byte parser and running sums: one frame byte per cycle while ready, frame summary registered on the last byte.
// Depends on udpfhc_pkg and the udpfhc_byte_if interface.
module udpfhc_accum #(
	parameter int MAX_SUM_BYTES   = udpfhc_pkg::MAX_SUM_BYTES_DEF,
	parameter int MAX_FRAME_BYTES = udpfhc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int PSUM_W          = udpfhc_pkg::psum_width(MAX_SUM_BYTES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	udpfhc_byte_if.sink                      frame,
	input  logic                             fin_ready,
	output logic                             s1_valid,
	output udpfhc_pkg::frame_info_t          info_s1,
	output logic [udpfhc_pkg::HSUM_W-1:0]    hsum_s1,
	output logic [PSUM_W-1:0]                psum_s1
);

	localparam int POS_W      = $clog2(MAX_FRAME_BYTES + 1);
	localparam int REGION_END = udpfhc_pkg::UDP_START + MAX_SUM_BYTES - 1;

	logic [POS_W-1:0]              pos_q;
	logic [7:0]                    held_q;
	logic [15:0]                   ether_q;
	logic [7:0]                    proto_q;
	logic [15:0]                   dport_q;
	logic [15:0]                   ulen_q;
	logic [udpfhc_pkg::HSUM_W-1:0] hsum_q;
	logic [PSUM_W-1:0]             psum_q;

	logic [POS_W-1:0]              pos_n;
	logic [7:0]                    held_n;
	logic [15:0]                   ether_n;
	logic [7:0]                    proto_n;
	logic [15:0]                   dport_n;
	logic [15:0]                   ulen_n;
	logic [udpfhc_pkg::HSUM_W-1:0] hsum_n;
	logic [PSUM_W-1:0]             psum_n;

	logic [31:0] p;
	logic        active;
	logic        odd;
	logic        in_region;
	logic [15:0] w;
	logic [15:0] payload_add;
	logic        accept;
	logic        frame_end;

	assign frame.ready = !s1_valid || fin_ready;
	assign accept      = frame.valid && frame.ready;
	assign frame_end   = accept && frame.last_byte;

	assign p         = 32'(pos_q);
	assign active    = p < 32'(MAX_FRAME_BYTES);
	assign odd       = pos_q[0];
	assign w         = {held_q, frame.data_byte};
	assign in_region = (p >= 32'(udpfhc_pkg::UDP_START)) && (p <= 32'(REGION_END));

	always_comb begin
		payload_add = '0;
		if (in_region) begin
			if (odd) begin
				if (p != 32'(udpfhc_pkg::POS_UCHECK)) begin
					payload_add = w;
				end
			end else if (frame.last_byte || p == 32'(REGION_END) ||
				p == 32'(MAX_FRAME_BYTES - 1)) begin
				payload_add = {frame.data_byte, 8'h00};
			end
		end
	end

	always_comb begin
		pos_n   = pos_q;
		held_n  = held_q;
		ether_n = ether_q;
		proto_n = proto_q;
		dport_n = dport_q;
		ulen_n  = ulen_q;
		hsum_n  = hsum_q;
		psum_n  = psum_q;
		if (active) begin
			pos_n  = pos_q + POS_W'(1);
			psum_n = psum_q + PSUM_W'(payload_add);
			if (!odd) begin
				held_n = frame.data_byte;
			end else begin
				if (p == 32'(udpfhc_pkg::POS_ETHERTYPE)) begin
					ether_n = w;
				end
				if (p >= 32'(udpfhc_pkg::POS_HDR_FIRST) && p <= 32'(udpfhc_pkg::POS_HDR_LAST)) begin
					hsum_n = hsum_q + udpfhc_pkg::HSUM_W'(w);
				end
				if (p == 32'(udpfhc_pkg::POS_DPORT)) begin
					dport_n = w;
				end
				if (p == 32'(udpfhc_pkg::POS_ULEN)) begin
					ulen_n = w;
				end
			end
			if (p == 32'(udpfhc_pkg::POS_PROTO)) begin
				proto_n = frame.data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			held_q  <= '0;
			ether_q <= '0;
			proto_q <= '0;
			dport_q <= '0;
			ulen_q  <= '0;
			hsum_q  <= '0;
			psum_q  <= '0;
		end else if (frame_end) begin
			pos_q   <= '0;
			held_q  <= '0;
			ether_q <= '0;
			proto_q <= '0;
			dport_q <= '0;
			ulen_q  <= '0;
			hsum_q  <= '0;
			psum_q  <= '0;
		end else if (accept) begin
			pos_q   <= pos_n;
			held_q  <= held_n;
			ether_q <= ether_n;
			proto_q <= proto_n;
			dport_q <= dport_n;
			ulen_q  <= ulen_n;
			hsum_q  <= hsum_n;
			psum_q  <= psum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (frame_end) begin
			s1_valid <= 1'b1;
		end else if (fin_ready) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end) begin
			info_s1.long_enough <= 32'(pos_n) >= 32'(udpfhc_pkg::MIN_FRAME);
			info_s1.ether_type  <= ether_n;
			info_s1.ip_protocol <= proto_n;
			info_s1.dest_port   <= dport_n;
			info_s1.udp_length  <= ulen_n;
			hsum_s1             <= hsum_n;
			psum_s1             <= psum_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= 32'(MAX_FRAME_BYTES))
		else $error("byte position ran past the frame limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		frame_end |=> (pos_q == '0) && (psum_q == '0) && s1_valid)
		else $error("frame end did not clear the sums and load the summary");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !fin_ready) |=> (s1_valid && $stable(psum_s1) && $stable(hsum_s1)))
		else $error("frame summary changed while waiting for the finish stage");

endmodule

>>> rtl/udpfhc_finish.sv
// Verdict and checksum finish stage: adds address words, folds carries, registers the result beat.
// Depends on udpfhc_pkg and the udpfhc_result_if interface.
module udpfhc_finish #(
	parameter int MAX_SUM_BYTES = udpfhc_pkg::MAX_SUM_BYTES_DEF,
	parameter int PSUM_W        = udpfhc_pkg::psum_width(MAX_SUM_BYTES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  udpfhc_pkg::cfg_t                 cfg,
	input  logic                             s1_valid,
	input  udpfhc_pkg::frame_info_t          info_s1,
	input  logic [udpfhc_pkg::HSUM_W-1:0]    hsum_s1,
	input  logic [PSUM_W-1:0]                psum_s1,
	output logic                             fin_ready,
	udpfhc_result_if.source                  result
);

	localparam int UFIN_W = PSUM_W + 2;

	logic [udpfhc_pkg::ADDR_W-1:0] addr_sum;
	logic [udpfhc_pkg::HFIN_W-1:0] hfin;
	logic [UFIN_W-1:0]             ufin;
	logic                          redirect;
	logic                          take;
	logic                          valid_q;
	logic                          verdict_q;
	logic [15:0]                   ifc_q;
	logic [15:0]                   hc_q;
	logic [15:0]                   uc_q;

	assign fin_ready = !valid_q || result.ready;
	assign take      = s1_valid && fin_ready;

	assign addr_sum = udpfhc_pkg::ADDR_W'(cfg.new_source_ip[31:16]) +
		udpfhc_pkg::ADDR_W'(cfg.new_source_ip[15:0]) +
		udpfhc_pkg::ADDR_W'(cfg.new_dest_ip[31:16]) +
		udpfhc_pkg::ADDR_W'(cfg.new_dest_ip[15:0]);

	assign hfin = udpfhc_pkg::HFIN_W'(hsum_s1) + udpfhc_pkg::HFIN_W'(addr_sum);
	assign ufin = UFIN_W'(psum_s1) + UFIN_W'(addr_sum) +
		UFIN_W'(udpfhc_pkg::PROTO_UDP) + UFIN_W'(info_s1.udp_length);

	assign redirect = info_s1.long_enough &&
		(info_s1.ether_type == udpfhc_pkg::ETHERTYPE_IPV4) &&
		(info_s1.ip_protocol == udpfhc_pkg::PROTO_UDP) &&
		(info_s1.dest_port == cfg.listen_port);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fin_ready) begin
			valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			verdict_q <= redirect;
			ifc_q     <= redirect ? cfg.egress_interface : 16'h0000;
			hc_q      <= redirect ? udpfhc_pkg::finish_sum(32'(hfin)) : 16'h0000;
			uc_q      <= redirect ? udpfhc_pkg::finish_sum(32'(ufin)) : 16'h0000;
		end
	end

	assign result.valid           = valid_q;
	assign result.verdict         = verdict_q;
	assign result.out_interface   = ifc_q;
	assign result.header_checksum = hc_q;
	assign result.udp_checksum    = uc_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_q)
		else $error("frame summary taken without producing a result beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !verdict_q) |-> ((ifc_q == 16'h0000) && (hc_q == 16'h0000) &&
		(uc_q == 16'h0000)))
		else $error("pass verdict carries nonzero fields");

endmodule

>>> verif/tb_udp_forward_header_checksum.sv
// Testbench for udp_forward_header_checksum: streams Ethernet frames byte by byte and checks each verdict,
// egress interface and both rewritten checksums against a cycle-free model kept in this file.
// Depends on udpfhc_pkg, udpfhc_byte_if, udpfhc_result_if and the block itself.
`timescale 1ns / 1ps

module tb_udp_forward_header_checksum;

	localparam int SUM_FROM    = 34;
	localparam int SUM_BYTES   = 1480;
	localparam int REGION_END  = SUM_FROM + SUM_BYTES - 1;
	localparam int FRAME_CAP   = 2048;
	localparam int SHORT_LIMIT = 42;
	localparam int STUCK_LIMIT = 2000;
	localparam int RAND_BYTES  = 900;
	localparam int RAND_FRAMES = 40;

	localparam logic [15:0] PORT_RST   = 16'd7999;
	localparam logic [31:0] SRC_IP_RST = 32'd3232299371;
	localparam logic [31:0] DST_IP_RST = 32'd3232299314;
	localparam logic [15:0] EGRESS_RST = 16'd5;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	typedef struct packed {
		logic        verdict;
		logic [15:0] iface;
		logic [15:0] hdr_csum;
		logic [15:0] udp_csum;
	} verdict_t;

	typedef enum {FRM_GOOD, FRM_BAD_TYPE, FRM_BAD_PROTO, FRM_BAD_PORT, FRM_NOISE} frame_kind_e;
	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [udpfhc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [udpfhc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	udpfhc_byte_if   frame_bus ();
	udpfhc_result_if result_bus ();

	udp_forward_header_checksum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.frame     (frame_bus),
		.result    (result_bus)
	);

	// Register copies seen by the checksum model.
	logic [15:0] cfg_port;
	logic [31:0] cfg_src_ip;
	logic [31:0] cfg_dst_ip;
	logic [15:0] cfg_egress;

	// Per-frame parse state of the model.
	logic [11:0] byte_pos;
	logic [7:0]  held_byte;
	logic [15:0] etype_word;
	logic [7:0]  proto_byte;
	logic [15:0] dport_word;
	logic [15:0] ulen_word;
	logic [19:0] hdr_sum;
	logic [26:0] udp_sum;

	frame_beat_t byte_q[$];
	verdict_t    verdict_q[$];
	logic [7:0]  frame_buf[];
	frame_beat_t next_beat;

	int errors;
	int rand_bytes;
	int rand_frames;
	int src_gap;
	int sink_stall;
	int stuck_cycles;
	bit src_gaps_on;
	bit sink_stalls_on;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [15:0] fold16(input logic [31:0] s);
		logic [31:0] t;
		t = s[15:0] + s[31:16];
		t = t[15:0] + t[31:16];
		return t[15:0];
	endfunction

	function automatic void clear_parse();
		byte_pos = '0;
		held_byte = '0;
		etype_word = '0;
		proto_byte = '0;
		dport_word = '0;
		ulen_word = '0;
		hdr_sum = '0;
		udp_sum = '0;
	endfunction

	function automatic void track_frame_byte(input logic [7:0] b, input logic last);
		logic [15:0] word;
		logic [31:0] addr;
		verdict_t res;
		word = {held_byte, b};
		if (byte_pos < FRAME_CAP) begin
			if (!byte_pos[0]) begin
				held_byte = b;
			end else begin
				if (byte_pos == 13)
					etype_word = word;
				if (byte_pos >= 15 && byte_pos <= 23)
					hdr_sum = hdr_sum + word;
				if (byte_pos == 37)
					dport_word = word;
				if (byte_pos == 39)
					ulen_word = word;
			end
			if (byte_pos == 23)
				proto_byte = b;
			if (byte_pos >= SUM_FROM && byte_pos <= REGION_END) begin
				if (byte_pos[0]) begin
					if (byte_pos != 41)
						udp_sum = udp_sum + word;
				end else if (last || byte_pos == REGION_END || byte_pos == FRAME_CAP - 1) begin
					udp_sum = udp_sum + {b, 8'h00};
				end
			end
			byte_pos = byte_pos + 1'b1;
		end
		if (last) begin
			res = '0;
			addr = cfg_src_ip[31:16] + cfg_src_ip[15:0] + cfg_dst_ip[31:16] + cfg_dst_ip[15:0];
			if (byte_pos >= SHORT_LIMIT && etype_word == udpfhc_pkg::ETHERTYPE_IPV4 &&
				proto_byte == udpfhc_pkg::PROTO_UDP && dport_word == cfg_port) begin
				res.verdict = 1'b1;
				res.iface = cfg_egress;
				res.hdr_csum = ~fold16(hdr_sum + addr);
				res.udp_csum = ~fold16(udp_sum + addr + udpfhc_pkg::PROTO_UDP + ulen_word);
			end
			verdict_q.push_back(res);
			clear_parse();
		end
	endfunction

	task automatic report_error(input string what);
		$display("ERROR at %0t: %s", $time, what);
		errors++;
	endtask

	task automatic check_result();
		verdict_t want;
		if (verdict_q.size() == 0) begin
			report_error("result beat with no frame outstanding");
		end else begin
			want = verdict_q.pop_front();
			if (result_bus.verdict !== want.verdict)
				report_error($sformatf("verdict got %0d want %0d",
					result_bus.verdict, want.verdict));
			if (result_bus.out_interface !== want.iface)
				report_error($sformatf("out_interface got %h want %h",
					result_bus.out_interface, want.iface));
			if (result_bus.header_checksum !== want.hdr_csum)
				report_error($sformatf("header_checksum got %h want %h",
					result_bus.header_checksum, want.hdr_csum));
			if (result_bus.udp_checksum !== want.udp_csum)
				report_error($sformatf("udp_checksum got %h want %h",
					result_bus.udp_checksum, want.udp_csum));
		end
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bus.valid <= 1'b0;
			frame_bus.data_byte <= '0;
			frame_bus.last_byte <= 1'b0;
			src_gap <= 0;
		end else if (!frame_bus.valid || frame_bus.ready) begin
			if (src_gap != 0) begin
				frame_bus.valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (byte_q.size() != 0) begin
				next_beat = byte_q.pop_front();
				frame_bus.valid <= 1'b1;
				frame_bus.data_byte <= next_beat.data;
				frame_bus.last_byte <= next_beat.last;
				src_gap <= src_gaps_on ? idle_len() : 0;
			end else begin
				frame_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			result_bus.ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
			result_bus.ready <= 1'b0;
			sink_stall <= idle_len();
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready)
				check_result();
			if (frame_bus.valid && frame_bus.ready)
				track_frame_byte(frame_bus.data_byte, frame_bus.last_byte);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (frame_bus.valid && frame_bus.ready) ||
			(result_bus.valid && result_bus.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("udp_forward_header_checksum test failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic write_reg(input udpfhc_pkg::cfg_reg_e idx, input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			udpfhc_pkg::REG_LISTEN_PORT: cfg_port = value[15:0];
			udpfhc_pkg::REG_NEW_SRC_IP:  cfg_src_ip = value;
			udpfhc_pkg::REG_NEW_DST_IP:  cfg_dst_ip = value;
			udpfhc_pkg::REG_EGRESS_IF:   cfg_egress = value[15:0];
			default: ;
		endcase
	endtask

	task automatic put(input int idx, input logic [7:0] value);
		if (idx < frame_buf.size())
			frame_buf[idx] = value;
	endtask

	task automatic new_frame(input int len, input frame_kind_e kind, input fill_e fill);
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [15:0] port;
		logic [15:0] ulen;
		frame_buf = new[len];
		foreach (frame_buf[i]) begin
			case (fill)
				FILL_ZERO: frame_buf[i] = 8'h00;
				FILL_ONES: frame_buf[i] = 8'hff;
				default:   frame_buf[i] = 8'($urandom_range(0, 255));
			endcase
		end
		if (kind != FRM_NOISE) begin
			etype = udpfhc_pkg::ETHERTYPE_IPV4;
			proto = udpfhc_pkg::PROTO_UDP;
			port = cfg_port;
			if (fill == FILL_ONES)
				ulen = 16'hffff;
			else if ($urandom_range(0, 9) < 7)
				ulen = 16'(len - SUM_FROM);
			else
				ulen = 16'($urandom);
			if (kind == FRM_BAD_TYPE)
				etype = etype ^ (16'h1 << $urandom_range(0, 15));
			if (kind == FRM_BAD_PROTO)
				proto = proto ^ (8'h1 << $urandom_range(0, 7));
			if (kind == FRM_BAD_PORT)
				port = port ^ (16'h1 << $urandom_range(0, 15));
			put(12, etype[15:8]);
			put(13, etype[7:0]);
			put(23, proto);
			put(36, port[15:8]);
			put(37, port[7:0]);
			put(38, ulen[15:8]);
			put(39, ulen[7:0]);
		end
	endtask

	task automatic queue_frame();
		frame_beat_t beat;
		foreach (frame_buf[i]) begin
			beat.data = frame_buf[i];
			beat.last = (i == frame_buf.size() - 1);
			byte_q.push_back(beat);
		end
	endtask

	task automatic send_frame(input int len, input frame_kind_e kind, input fill_e fill);
		new_frame(len, kind, fill);
		queue_frame();
	endtask

	// Picks the first payload word so that the UDP checksum comes out as zero.
	task automatic send_zero_udp_check();
		logic [31:0] s;
		logic [15:0] w;
		new_frame(44, FRM_GOOD, FILL_RANDOM);
		s = cfg_src_ip[31:16] + cfg_src_ip[15:0] + cfg_dst_ip[31:16] + cfg_dst_ip[15:0] +
			udpfhc_pkg::PROTO_UDP + {frame_buf[38], frame_buf[39]} +
			{frame_buf[34], frame_buf[35]} + {frame_buf[36], frame_buf[37]} +
			{frame_buf[38], frame_buf[39]};
		w = ~fold16(s);
		frame_buf[42] = w[15:8];
		frame_buf[43] = w[7:0];
		queue_frame();
	endtask

	task automatic random_frames(input int count);
		int len;
		int r;
		frame_kind_e kind;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				len = $urandom_range(1, 41);
			else if (r < 95)
				len = $urandom_range(42, 80);
			else if (r < 99)
				len = $urandom_range(81, 300);
			else
				len = $urandom_range(1400, 2100);
			r = $urandom_range(0, 99);
			if (r < 70)
				kind = FRM_GOOD;
			else if (r < 77)
				kind = FRM_BAD_TYPE;
			else if (r < 84)
				kind = FRM_BAD_PROTO;
			else if (r < 92)
				kind = FRM_BAD_PORT;
			else
				kind = FRM_NOISE;
			send_frame(len, kind, FILL_RANDOM);
			rand_bytes += len;
			rand_frames++;
		end
	endtask

	task automatic wait_idle();
		while (byte_q.size() != 0 || frame_bus.valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = udpfhc_pkg::REG_LISTEN_PORT;
		cfg_wdata = '0;
		cfg_port = PORT_RST;
		cfg_src_ip = SRC_IP_RST;
		cfg_dst_ip = DST_IP_RST;
		cfg_egress = EGRESS_RST;
		clear_parse();
		errors = 0;
		rand_bytes = 0;
		rand_frames = 0;
		src_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: minimal, padded, short and rejected frames, then long ones.
		send_frame(42, FRM_GOOD, FILL_RANDOM);
		send_frame(43, FRM_GOOD, FILL_RANDOM);
		send_frame(41, FRM_GOOD, FILL_RANDOM);
		send_frame(1, FRM_GOOD, FILL_RANDOM);
		send_frame(60, FRM_BAD_TYPE, FILL_RANDOM);
		send_frame(60, FRM_BAD_PROTO, FILL_RANDOM);
		send_frame(60, FRM_BAD_PORT, FILL_RANDOM);
		send_frame(64, FRM_NOISE, FILL_RANDOM);
		send_zero_udp_check();
		send_frame(42, FRM_GOOD, FILL_ZERO);
		send_frame(1513, FRM_GOOD, FILL_RANDOM);
		send_frame(1516, FRM_GOOD, FILL_RANDOM);
		send_frame(2049, FRM_GOOD, FILL_RANDOM);
		send_frame(2060, FRM_GOOD, FILL_RANDOM);
		wait_idle();

		write_reg(udpfhc_pkg::REG_LISTEN_PORT, 32'hffff_ffff);
		write_reg(udpfhc_pkg::REG_NEW_SRC_IP, 32'hffff_ffff);
		write_reg(udpfhc_pkg::REG_NEW_DST_IP, 32'hffff_ffff);
		write_reg(udpfhc_pkg::REG_EGRESS_IF, 32'hffff_ffff);
		send_frame(64, FRM_GOOD, FILL_ONES);
		send_frame(65, FRM_GOOD, FILL_ONES);
		send_zero_udp_check();
		random_frames(6);
		wait_idle();

		write_reg(udpfhc_pkg::REG_EGRESS_IF, 32'h0);
		write_reg(udpfhc_pkg::REG_NEW_DST_IP, 32'h0);
		write_reg(udpfhc_pkg::REG_NEW_SRC_IP, 32'h0);
		write_reg(udpfhc_pkg::REG_LISTEN_PORT, 32'h0);
		send_frame(42, FRM_GOOD, FILL_ZERO);
		send_frame(50, FRM_GOOD, FILL_ONES);
		random_frames(6);
		wait_idle();

		while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
			if ($urandom_range(0, 1))
				write_reg(udpfhc_pkg::REG_LISTEN_PORT, $urandom);
			if ($urandom_range(0, 1))
				write_reg(udpfhc_pkg::REG_NEW_SRC_IP, $urandom);
			if ($urandom_range(0, 1))
				write_reg(udpfhc_pkg::REG_NEW_DST_IP, $urandom);
			if ($urandom_range(0, 1))
				write_reg(udpfhc_pkg::REG_EGRESS_IF, $urandom);
			src_gaps_on = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			random_frames(6);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("udp_forward_header_checksum test passed");
		else
			$display("udp_forward_header_checksum test failed");
		$finish;
	end

endmodule
